// ----- rtl/jsu_pkg.sv -----
// Shared types, constants and helper functions for the JSON string unescape unit.
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_NO_OPEN_QUOTE  = 4'd1,
    ERR_CONTROL_BYTE   = 4'd2,
    ERR_BAD_ESCAPE     = 4'd3,
    ERR_BAD_HEX        = 4'd4,
    ERR_BAD_SURROGATE  = 4'd5,
    ERR_UNTERMINATED   = 4'd6,
    ERR_INCOMPLETE_ESC = 4'd7,
    ERR_INCOMPLETE_UNI = 4'd8
  } err_code_t;

  typedef enum logic [6:0] {
    MODE_IDLE      = 7'b0000001,
    MODE_STR       = 7'b0000010,
    MODE_ESC       = 7'b0000100,
    MODE_HEX_FIRST = 7'b0001000,
    MODE_WANT_BSL  = 7'b0010000,
    MODE_WANT_U    = 7'b0100000,
    MODE_HEX_LOW   = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic [3:0] error_code;
    logic       last;
  } out_item_t;

  // One queued job: the results caused by a single input byte.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            byte_valid;
    logic            string_end;
    logic [3:0]      error_code;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Digit value in the low four bits; bit 4 is set for a byte that is not hex.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end
    return d;
  endfunction

  function automatic job_t utf8_encode(input logic [20:0] cp);
    job_t j;
    j = '0;
    j.byte_valid = 1'b1;
    j.error_code = ERR_NONE;
    if (cp <= 21'h7F) begin
      j.bytes[0] = cp[7:0];
      j.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

endpackage

// ----- rtl/jsu_front.sv -----
// Front end: accepts text bytes, tracks the string and escape state and builds result jobs.
module jsu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  jsu_pkg::in_item_t   in_data,
  input  jsu_pkg::q_status_t  q_status,
  output logic                push,
  output jsu_pkg::job_t       push_job
);

  jsu_pkg::mode_t mode, mode_next;
  logic [11:0]    hex_acc, hex_acc_next;
  logic [1:0]     hex_cnt, hex_cnt_next;
  logic [9:0]     high_bits, high_bits_next;

  logic           accept;
  logic           has_job;
  logic           fail_en;
  logic [3:0]     fail_code;
  logic [4:0]     digit;
  logic [15:0]    hex_word;
  logic [20:0]    pair_cp;
  logic [7:0]     c;
  jsu_pkg::job_t  job;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign c        = in_data.data_byte;
  assign digit    = jsu_pkg::hex_value(c);
  assign hex_word = {hex_acc, digit[3:0]};
  assign pair_cp  = jsu_pkg::SUPPLEMENTARY_BASE + {1'b0, high_bits, 10'b0}
                    + {11'b0, hex_word[9:0]};

  always_comb begin
    mode_next      = mode;
    hex_acc_next   = hex_acc;
    hex_cnt_next   = hex_cnt;
    high_bits_next = high_bits;
    has_job        = 1'b0;
    fail_en        = 1'b0;
    fail_code      = jsu_pkg::ERR_NONE;
    job            = '0;

    if (in_data.end_of_text) begin
      unique case (mode)
        jsu_pkg::MODE_STR: begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::ERR_UNTERMINATED;
        end
        jsu_pkg::MODE_ESC: begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::ERR_INCOMPLETE_ESC;
        end
        jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_LOW: begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::ERR_INCOMPLETE_UNI;
        end
        jsu_pkg::MODE_WANT_BSL, jsu_pkg::MODE_WANT_U: begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::ERR_BAD_SURROGATE;
        end
        default: begin
          mode_next      = jsu_pkg::MODE_IDLE;
          hex_acc_next   = '0;
          hex_cnt_next   = '0;
          high_bits_next = '0;
        end
      endcase
    end else begin
      unique case (mode)
        jsu_pkg::MODE_STR: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            mode_next      = jsu_pkg::MODE_IDLE;
            has_job        = 1'b1;
            job.string_end = 1'b1;
          end else if (c < jsu_pkg::CH_SPACE) begin
            fail_en   = 1'b1;
            fail_code = jsu_pkg::ERR_CONTROL_BYTE;
          end else if (c == jsu_pkg::CH_BACKSLASH) begin
            mode_next = jsu_pkg::MODE_ESC;
          end else begin
            has_job        = 1'b1;
            job.bytes[0]   = c;
            job.byte_valid = 1'b1;
          end
        end
        jsu_pkg::MODE_ESC: begin
          has_job        = 1'b1;
          job.byte_valid = 1'b1;
          mode_next      = jsu_pkg::MODE_STR;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
                             job.bytes[0] = c;
            jsu_pkg::CH_B:   job.bytes[0] = 8'h08;
            jsu_pkg::CH_F:   job.bytes[0] = 8'h0C;
            jsu_pkg::CH_N:   job.bytes[0] = 8'h0A;
            jsu_pkg::CH_R:   job.bytes[0] = 8'h0D;
            jsu_pkg::CH_T:   job.bytes[0] = 8'h09;
            jsu_pkg::CH_U: begin
              has_job      = 1'b0;
              mode_next    = jsu_pkg::MODE_HEX_FIRST;
              hex_acc_next = '0;
              hex_cnt_next = '0;
            end
            default: begin
              has_job   = 1'b0;
              fail_en   = 1'b1;
              fail_code = jsu_pkg::ERR_BAD_ESCAPE;
            end
          endcase
        end
        jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_LOW: begin
          if (digit[4]) begin
            fail_en   = 1'b1;
            fail_code = jsu_pkg::ERR_BAD_HEX;
          end else if (hex_cnt != 2'd3) begin
            hex_acc_next = hex_word[11:0];
            hex_cnt_next = hex_cnt + 2'd1;
          end else begin
            hex_acc_next = '0;
            hex_cnt_next = '0;
            if (mode == jsu_pkg::MODE_HEX_FIRST) begin
              if (hex_word >= jsu_pkg::HIGH_SURR_FIRST &&
                  hex_word <= jsu_pkg::HIGH_SURR_LAST) begin
                high_bits_next = hex_word[9:0];
                mode_next      = jsu_pkg::MODE_WANT_BSL;
              end else begin
                mode_next = jsu_pkg::MODE_STR;
                has_job   = 1'b1;
                job       = jsu_pkg::utf8_encode({5'b0, hex_word});
              end
            end else if (hex_word < jsu_pkg::LOW_SURR_FIRST ||
                         hex_word > jsu_pkg::LOW_SURR_LAST) begin
              fail_en   = 1'b1;
              fail_code = jsu_pkg::ERR_BAD_SURROGATE;
            end else begin
              high_bits_next = '0;
              mode_next      = jsu_pkg::MODE_STR;
              has_job        = 1'b1;
              job            = jsu_pkg::utf8_encode(pair_cp);
            end
          end
        end
        jsu_pkg::MODE_WANT_BSL: begin
          if (c == jsu_pkg::CH_BACKSLASH) begin
            mode_next = jsu_pkg::MODE_WANT_U;
          end else begin
            fail_en   = 1'b1;
            fail_code = jsu_pkg::ERR_BAD_SURROGATE;
          end
        end
        jsu_pkg::MODE_WANT_U: begin
          if (c == jsu_pkg::CH_U) begin
            mode_next    = jsu_pkg::MODE_HEX_LOW;
            hex_acc_next = '0;
            hex_cnt_next = '0;
          end else begin
            fail_en   = 1'b1;
            fail_code = jsu_pkg::ERR_BAD_SURROGATE;
          end
        end
        default: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            mode_next      = jsu_pkg::MODE_STR;
            hex_acc_next   = '0;
            hex_cnt_next   = '0;
            high_bits_next = '0;
          end else begin
            fail_en   = 1'b1;
            fail_code = jsu_pkg::ERR_NO_OPEN_QUOTE;
          end
        end
      endcase
    end

    // Every error reports once and drops the block back to waiting for a quote.
    if (fail_en) begin
      mode_next      = jsu_pkg::MODE_IDLE;
      hex_acc_next   = '0;
      hex_cnt_next   = '0;
      high_bits_next = '0;
      has_job        = 1'b1;
      job            = '0;
      job.error_code = fail_code;
    end
  end

  assign push     = accept && has_job;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jsu_pkg::MODE_IDLE;
      hex_acc   <= '0;
      hex_cnt   <= '0;
      high_bits <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_acc   <= hex_acc_next;
      hex_cnt   <= hex_cnt_next;
      high_bits <= high_bits_next;
    end
  end

endmodule

// ----- rtl/jsu_queue.sv -----
// Small job queue between the front end and the result sequencer.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jsu_pkg::job_t      push_job,
  input  logic               pop,
  output jsu_pkg::job_t      head,
  output jsu_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/jsu_back.sv -----
// Back end: steps through the bytes of the job at the queue head, one result per transaction.
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  jsu_pkg::job_t       head,
  input  jsu_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output jsu_pkg::out_item_t  out_data
);

  logic [1:0] idx;
  logic       is_last;
  logic       taken;

  assign out_valid = !q_status.empty;
  assign is_last   = (idx == head.last_idx);
  assign taken     = out_valid && !out_stall;
  assign pop       = taken && is_last;

  always_comb begin
    out_data            = '0;
    out_data.out_byte   = head.byte_valid ? head.bytes[idx] : 8'h00;
    out_data.byte_valid = head.byte_valid;
    out_data.string_end = head.string_end;
    out_data.error_code = head.error_code;
    out_data.last       = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (taken) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ----- rtl/json_string_unescape_utf8_unit.sv -----
// Top level of the JSON string unescape unit with UTF-8 output.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall   jsu_pkg::in_item_t  (data_byte, end_of_text)
//   out      output     out_valid/out_stall jsu_pkg::out_item_t (out_byte .. last)
//
// One text byte is accepted per cycle while the job queue has a free slot.
// Each result is one output transaction; a byte that decodes to a four-byte
// code point yields four results, stepped out by the result sequencer.
// A byte's results are held in the job queue memory before they reach the output.
// Reset clears the decode state and empties the queue.
// Output stalls back up into the queue; input stalls only when it is full.
module json_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_data
);

  jsu_pkg::q_status_t q_status;
  jsu_pkg::job_t      push_job;
  jsu_pkg::job_t      head;
  logic               push;
  logic               pop;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/jsu_checker.sv -----
// Port-level checks for the JSON string unescape unit, bound to the top level.
module jsu_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input jsu_pkg::out_item_t out_data
);

  // A stalled result must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset leaves nothing queued for output.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // A decoded byte never carries an error or a string end.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_valid |->
      out_data.error_code == jsu_pkg::ERR_NONE && !out_data.string_end)
    else $error("decoded byte flagged as error or string end");

  // Error and string-end results stand alone with a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.last && out_data.out_byte == 8'h00)
    else $error("status result not single or byte not zero");

  // A byte taken before the end of its multi-byte sequence is followed by a continuation byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.byte_valid && !out_data.last |=>
      out_valid && out_data.byte_valid && out_data.out_byte[7:6] == 2'b10)
    else $error("multi-byte sequence broken");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
